// ===== src/brc_pkg.sv =====
package brc_pkg;

   localparam int MAX_ROWS  = 64;
   localparam int MAX_COLS  = 64;
   localparam int LANE_W    = 8;
   localparam int LANES     = MAX_COLS / LANE_W;
   localparam int ROW_AW    = $clog2(MAX_ROWS);
   localparam int CNT_W     = $clog2(MAX_ROWS + 1);
   localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
   localparam int LANE_CW   = $clog2(LANE_W + 1);
   localparam int CFG_W     = 7;

   // register index of the configuration port
   localparam logic REG_IMAGE_WIDTH = 1'b0;

   typedef struct packed {
      logic [63:0] row_pixels;
      logic        last_row;
   } req_type;

   typedef struct packed {
      logic [63:0] packed_row;
      logic [6:0]  kept_width;
      logic        last_out;
      logic        empty_image;
      logic        overflow;
   } rsp_type;

   // what one lane found in its slice of a row
   typedef struct packed {
      logic [LANE_W-1:0]  gathered;
      logic [LANE_CW-1:0] count;
   } lane_out_type;

endpackage

// ===== src/blank_row_column_compactor_core.sv =====
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   brc_pkg::req_type (row_pixels, last_row)
// rsp       out        rsp_valid/rsp_stall   brc_pkg::rsp_type (packed_row .. overflow)
// csr       in/out     psel/penable/pready   image_width at byte address 0
//
// Rows load at one request per cycle while the core is collecting an image.
// After the last row the core stops taking requests and reads the row memory
// back at one stored row per cycle unless a stalled result holds it (its single
// read port sets this figure), then waits while the read and lane registers drain.
// An image with no black pixel yields a single empty-image result.
// Reset is synchronous and active high; the row memory itself is not cleared.
// A stalled result freezes the whole readout pipeline in place.
module blank_row_column_compactor_core (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  brc_pkg::req_type              req_data,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output brc_pkg::rsp_type              rsp_data,

   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   typedef enum logic [3:0] {
      S_LOAD  = 4'b0001,
      S_READ  = 4'b0010,
      S_DRAIN = 4'b0100,
      S_EMPTY = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [brc_pkg::CFG_W-1:0] image_width_ff;
   logic                      csr_write;

   // image collection state
   logic [brc_pkg::MAX_COLS-1:0] column_any_ff, column_any_in;
   logic [brc_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                         ovf_ff, ovf_in;
   logic [brc_pkg::ROW_AW-1:0]   last_nb_ff, last_nb_in;
   logic [brc_pkg::CNT_W-1:0]    rd_idx_ff, rd_idx_in;

   // row memory
   logic [brc_pkg::MAX_COLS-1:0] row_mem [brc_pkg::MAX_ROWS];
   logic [brc_pkg::MAX_COLS-1:0] rd_data_ff;

   // readout pipeline
   logic s1_v_ff, s1_last_ff;
   logic s2_v_ff, s2_last_ff;
   logic advance;
   logic rd_en;
   logic row_accept;
   logic wr_en;
   logic finish;

   logic [brc_pkg::CFG_W-1:0]    eff_width;
   logic [brc_pkg::MAX_COLS-1:0] width_mask;
   logic [brc_pkg::MAX_COLS-1:0] row_masked;

   brc_pkg::lane_out_type         lane_out [brc_pkg::LANES];
   logic [brc_pkg::MAX_COLS-1:0]  merged_row;
   logic [brc_pkg::COL_CNT_W-1:0] merged_width;

   logic             rsp_valid_ff;
   brc_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             rsp_valid_in;

   // ---------------------------------------------------------------------
   // Configuration port: always ready, single register at index 0
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= brc_pkg::CFG_W'(brc_pkg::MAX_COLS);
      end else if (csr_write && (paddr[2] == brc_pkg::REG_IMAGE_WIDTH)) begin
         image_width_ff <= pwdata[brc_pkg::CFG_W-1:0];
      end
   end

   assign prdata = (paddr[2] == brc_pkg::REG_IMAGE_WIDTH)
                 ? 32'(image_width_ff) : 32'd0;

   // ---------------------------------------------------------------------
   // Row masking: width 0 acts as 1, anything above the row size saturates
   // ---------------------------------------------------------------------
   always_comb begin
      if (image_width_ff == '0) begin
         eff_width = brc_pkg::CFG_W'(1);
      end else if (image_width_ff > brc_pkg::CFG_W'(brc_pkg::MAX_COLS)) begin
         eff_width = brc_pkg::CFG_W'(brc_pkg::MAX_COLS);
      end else begin
         eff_width = image_width_ff;
      end
      for (int c = 0; c < brc_pkg::MAX_COLS; c++) begin
         width_mask[c] = brc_pkg::CFG_W'(c) < eff_width;
      end
   end

   assign row_masked = req_data.row_pixels[brc_pkg::MAX_COLS-1:0] & width_mask;

   // ---------------------------------------------------------------------
   // Control: collect rows, then read back the stored ones
   // ---------------------------------------------------------------------
   assign req_stall  = (state_ff != S_LOAD);
   assign row_accept = req_valid && !req_stall;
   assign wr_en      = row_accept && (count_ff < brc_pkg::CNT_W'(brc_pkg::MAX_ROWS));

   // hold the readout while a finished result is not taken
   assign advance = !(rsp_valid_ff && rsp_stall);
   assign rd_en   = (state_ff == S_READ) && advance;

   always_comb begin
      state_in      = state_ff;
      column_any_in = column_any_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      last_nb_in    = last_nb_ff;
      rd_idx_in     = rd_idx_ff;
      finish        = 1'b0;

      case (state_ff)
         S_LOAD: begin
            if (row_accept) begin
               if (wr_en) begin
                  column_any_in = column_any_ff | row_masked;
                  count_in      = count_ff + 1'b1;
                  if (row_masked != '0) begin
                     last_nb_in = count_ff[brc_pkg::ROW_AW-1:0];
                  end
               end else begin
                  // drop the row, remember that capacity ran out
                  ovf_in = 1'b1;
               end
               if (req_data.last_row) begin
                  state_in = (column_any_in == '0) ? S_EMPTY : S_READ;
               end
            end
         end
         S_READ: begin
            if (advance) begin
               rd_idx_in = rd_idx_ff + 1'b1;
               if (rd_idx_ff == brc_pkg::CNT_W'(count_ff - 1'b1)) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            if (!s1_v_ff && !s2_v_ff) begin
               finish = 1'b1;
            end
         end
         S_EMPTY: begin
            if (advance) begin
               finish = 1'b1;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      // clear the image state, ready for the next image
      if (finish) begin
         state_in      = S_LOAD;
         column_any_in = '0;
         count_in      = '0;
         ovf_in        = 1'b0;
         last_nb_in    = '0;
         rd_idx_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         column_any_ff <= '0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         last_nb_ff    <= '0;
         rd_idx_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         column_any_ff <= column_any_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         last_nb_ff    <= last_nb_in;
         rd_idx_ff     <= rd_idx_in;
      end
   end

   // ---------------------------------------------------------------------
   // Row memory: one write port for loading, one registered read port
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[count_ff[brc_pkg::ROW_AW-1:0]] <= row_masked;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= row_mem[rd_idx_ff[brc_pkg::ROW_AW-1:0]];
      end
   end

   // stage 1 tags: read issued, and whether it is the final non-blank row
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff    <= 1'b0;
         s1_last_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff    <= rd_en;
         s1_last_ff <= (rd_idx_ff[brc_pkg::ROW_AW-1:0] == last_nb_ff);
      end
   end

   // stage 2 tags: blank rows drop out here
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff    <= 1'b0;
         s2_last_ff <= 1'b0;
      end else if (advance) begin
         s2_v_ff    <= s1_v_ff && (rd_data_ff != '0);
         s2_last_ff <= s1_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Lanes: each gathers one slice of the row under the column mask
   // ---------------------------------------------------------------------
   for (genvar l = 0; l < brc_pkg::LANES; l++) begin : g_lane
      brc_lane u_lane (
         .clock      (clock),
         .enable     (advance),
         .row_slice  (rd_data_ff[l*brc_pkg::LANE_W +: brc_pkg::LANE_W]),
         .mask_slice (column_any_ff[l*brc_pkg::LANE_W +: brc_pkg::LANE_W]),
         .lane_out   (lane_out[l])
      );
   end

   brc_merge u_merge (
      .lanes_in   (lane_out),
      .packed_row (merged_row),
      .kept_width (merged_width)
   );

   // ---------------------------------------------------------------------
   // Result register: either the compacted row or the empty-image marker
   // ---------------------------------------------------------------------
   always_comb begin
      if (state_ff == S_EMPTY) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.packed_row  = '0;
         rsp_data_in.kept_width  = '0;
         rsp_data_in.last_out    = 1'b1;
         rsp_data_in.empty_image = 1'b1;
      end else begin
         rsp_valid_in            = s2_v_ff;
         rsp_data_in.packed_row  = 64'(merged_row);
         rsp_data_in.kept_width  = 7'(merged_width);
         rsp_data_in.last_out    = s2_last_ff;
         rsp_data_in.empty_image = 1'b0;
      end
      rsp_data_in.overflow = ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // the row count never passes the memory depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= brc_pkg::CNT_W'(brc_pkg::MAX_ROWS))
      else $error("row count beyond capacity");

   // the last row always ends the load phase
   a_last_starts_readout: assert property (@(posedge clock) disable iff (reset)
      (row_accept && req_data.last_row) |=> (state_ff != S_LOAD))
      else $error("last row did not start readout");

   // an empty-image result is final and carries no pixels
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.empty_image) |->
         (rsp_data.last_out && rsp_data.kept_width == '0 && rsp_data.packed_row == '0))
      else $error("malformed empty-image result");

   // a compacted row keeps at least one column
   a_nonempty_width: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.empty_image) |-> (rsp_data.kept_width != '0))
      else $error("compacted row with zero width");
`endif

endmodule

// ===== src/brc_lane.sv =====
module brc_lane (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic [brc_pkg::LANE_W-1:0]           row_slice,
   input  logic [brc_pkg::LANE_W-1:0]           mask_slice,
   output brc_pkg::lane_out_type                lane_out
);

   brc_pkg::lane_out_type lane_ff;
   brc_pkg::lane_out_type lane_in;

   // gather the slice bits at the set mask positions, packed from bit 0
   always_comb begin
      logic [brc_pkg::LANE_CW-1:0] pos;
      pos              = '0;
      lane_in.gathered = '0;
      for (int c = 0; c < brc_pkg::LANE_W; c++) begin
         if (mask_slice[c]) begin
            if (row_slice[c]) begin
               lane_in.gathered[pos[brc_pkg::LANE_CW-2:0]] = 1'b1;
            end
            pos = pos + 1'b1;
         end
      end
      lane_in.count = pos;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_out = lane_ff;

endmodule

// ===== src/brc_merge.sv =====
module brc_merge (
   input  brc_pkg::lane_out_type              lanes_in [brc_pkg::LANES],
   output logic [brc_pkg::MAX_COLS-1:0]       packed_row,
   output logic [brc_pkg::COL_CNT_W-1:0]      kept_width
);

   // place each lane's gathered bits after those of the lanes below it
   always_comb begin
      logic [brc_pkg::COL_CNT_W-1:0] offset;
      offset     = '0;
      packed_row = '0;
      for (int l = 0; l < brc_pkg::LANES; l++) begin
         packed_row = packed_row
                    | (brc_pkg::MAX_COLS'(lanes_in[l].gathered) << offset);
         offset     = offset + brc_pkg::COL_CNT_W'(lanes_in[l].count);
      end
      kept_width = offset;
   end

endmodule
